// ===== rtl/asba_pkg.sv =====
// Package for the aligned slot bitmap allocator.
// Holds the request codes, sequencer states, sizing constants and the word scan result type.
// No dependencies.
package asba_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 256;
  localparam int unsigned MAX_SLOTS      = 256;
  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned BIT_W          = 5;

  // Request kinds; the two codes above query carry no meaning.
  typedef enum logic [2:0] {
    KIND_ALLOC_FIRST = 3'd0,
    KIND_ALLOC_END   = 3'd1,
    KIND_ALLOC_AT    = 3'd2,
    KIND_RESERVE     = 3'd3,
    KIND_RELEASE     = 3'd4,
    KIND_QUERY       = 3'd5
  } kind_e;

  localparam logic [1:0] SPAN_REF = 2'd0;
  localparam logic [1:0] SPAN_ONE = 2'd1;
  localparam logic [1:0] SPAN_TWO = 2'd2;
  localparam logic [1:0] SPAN_BAD = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_FEND,
    ST_CHK_RD,
    ST_CHK_EVAL,
    ST_WR_RD,
    ST_WR_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             ff_found;
    logic [BIT_W-1:0] ff_bit;
    logic             hi_found;
    logic [BIT_W-1:0] hi_bit;
  } scan_res_t;

endpackage

// ===== rtl/asba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module asba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/asba_word_unit.sv =====
// Shared word evaluator: bound mask, first free aligned span and highest used slot of one word.
// Depends on asba_pkg.
module asba_word_unit
  import asba_pkg::*;
#(
  parameter int unsigned WORD_AW = 3
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WORD_AW-1:0]   word_idx_i,
  input  logic [8:0]           cap_i,
  input  logic                 two_i,
  output scan_res_t            res_o
);

  logic [9:0]           base;
  logic [WORD_BITS-1:0] incap;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] used;

  assign base = 10'(word_idx_i) << BIT_W;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      incap[b] = (base + 10'(b)) < {1'b0, cap_i};
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      used[b] = word_i[b] & incap[b];
      if (!two_i) begin
        cand[b] = ~word_i[b] & incap[b];
      end else if ((b % 2) == 0) begin
        cand[b] = ~word_i[b] & ~word_i[(b + 1) % WORD_BITS] & incap[(b + 1) % WORD_BITS];
      end else begin
        cand[b] = 1'b0;
      end
    end
  end

  always_comb begin
    res_o = '0;
    // Lowest candidate wins: scan downward so the last hit is the lowest.
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        res_o.ff_found = 1'b1;
        res_o.ff_bit   = BIT_W'(b);
      end
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (used[b]) begin
        res_o.hi_found = 1'b1;
        res_o.hi_bit   = BIT_W'(b);
      end
    end
  end

endmodule

// ===== rtl/aligned_slot_bitmap_allocator_unit.sv =====
// Aligned slot bitmap allocator: used-bit map in a word RAM, served by a small sequencer.
// One item at a time: a new item is accepted only after the result of the last one has been
// loaded into the output register, and a stalled result holds the unit in its done state. The
// scan of first-fit and from-end reads one map word per cycle.
// Reset: slots read free through per-word valid bits, high-water -1, active_slots 256.
module aligned_slot_bitmap_allocator_unit
  import asba_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [8:0]        cfg_active_slots_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        kind_i,
  input  logic [7:0]        slot_index_i,
  input  logic [1:0]        span_slots_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [7:0]        result_slot_o,
  output logic              slot_used_o,
  output logic signed [8:0] high_water_o
);

  // Slots beyond 256 can never fall under the usable bound, so the map stops there.
  localparam int unsigned MAP_SLOTS = (SLOT_COUNT < MAX_SLOTS) ? SLOT_COUNT : MAX_SLOTS;
  localparam int unsigned WORDS     = (MAP_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (WORDS > 1) ? $clog2(WORDS) : 1;

  state_e state_q, state_d;

  logic [8:0]           active_q;
  logic [2:0]           kind_q;
  logic [7:0]           idx_q;
  logic [1:0]           span_q;
  logic [7:0]           s_q, s_d;
  logic                 j_q, j_d;
  logic                 val_q, val_d;
  logic                 alloc_q, alloc_d;
  logic [8:0]           next_q, next_d;
  logic [AW:0]          w_q, w_d;
  logic [AW-1:0]        rdw_q, rdw_d;
  logic                 rvalid_q, rvalid_d;
  logic                 rd_vld_q;
  logic [WORDS-1:0]     vld_q;
  logic                 ok_q, ok_d;
  logic [7:0]           res_q, res_d;
  logic                 used_q, used_d;
  logic signed [8:0]    hw_q, hw_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_ok_q;
  logic [7:0]           out_res_q;
  logic                 out_used_q;
  logic signed [8:0]    out_hw_q;

  logic                 two;
  logic [8:0]           cap;
  logic                 idx_ok;
  logic                 span_in_range;
  logic [7:0]           cur_slot;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] cur_onehot;
  logic [WORD_BITS-1:0] ff_mask;
  logic [9:0]           eval_base;
  logic [7:0]           ff_slot;
  logic [8:0]           aligned;
  logic                 fend_fits;
  logic                 last_word;
  logic                 cur_used;
  logic                 done_load;
  scan_res_t            scan;

  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  asba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  asba_word_unit #(
    .WORD_AW (AW)
  ) u_word (
    .word_i     (word),
    .word_idx_i (rdw_q),
    .cap_i      (cap),
    .two_i      (two),
    .res_o      (scan)
  );

  // Shared decode of the latched item.
  assign two           = (span_q == SPAN_TWO);
  assign cap           = (active_q > 9'(MAP_SLOTS)) ? 9'(MAP_SLOTS) : active_q;
  assign idx_ok        = {1'b0, idx_q} < cap;
  assign span_in_range = ({2'b00, idx_q} + (two ? 10'd2 : 10'd1)) <= {1'b0, cap};
  assign cur_slot      = s_q + 8'(j_q);
  // A word that was never written reads as all free.
  assign word          = rd_vld_q ? ram_rdata : '0;
  assign cur_onehot    = WORD_BITS'(1) << cur_slot[BIT_W-1:0];
  assign cur_used      = word[cur_slot[BIT_W-1:0]];
  assign ff_mask       = (two ? WORD_BITS'(3) : WORD_BITS'(1)) << scan.ff_bit;
  assign eval_base     = 10'(rdw_q) << BIT_W;
  assign ff_slot       = 8'(eval_base | 10'(scan.ff_bit));
  assign last_word     = (rdw_q == AW'(WORDS - 1));
  assign aligned       = (two && next_q[0]) ? next_q + 9'd1 : next_q;
  assign fend_fits     = ({1'b0, aligned} + (two ? 10'd2 : 10'd1)) <= {1'b0, cap};
  assign done_load     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  function automatic logic signed [8:0] raise_hw(logic signed [8:0] hw, logic [7:0] top);
    raise_hw = (hw[8] || (top > hw[7:0])) ? $signed({1'b0, top}) : hw;
  endfunction

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (kind_q == KIND_QUERY) begin
          state_d = idx_ok ? ST_CHK_RD : ST_DONE;
        end else if (span_q == SPAN_BAD) begin
          state_d = ST_DONE;
        end else begin
          case (kind_q)
            KIND_ALLOC_FIRST, KIND_ALLOC_END: state_d = ST_SCAN;
            KIND_ALLOC_AT:                    state_d = span_in_range ? ST_CHK_RD : ST_DONE;
            KIND_RESERVE, KIND_RELEASE:       state_d = span_in_range ? ST_WR_RD : ST_DONE;
            default:                          state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (rvalid_q) begin
          if (kind_q == KIND_ALLOC_FIRST && scan.ff_found) begin
            state_d = ST_DONE;
          end else if (last_word) begin
            state_d = (kind_q == KIND_ALLOC_FIRST) ? ST_DONE : ST_FEND;
          end
        end
      end
      ST_FEND: begin
        state_d = fend_fits ? ST_WR_RD : ST_DONE;
      end
      ST_CHK_RD: begin
        state_d = ST_CHK_EVAL;
      end
      ST_CHK_EVAL: begin
        if (kind_q == KIND_QUERY || cur_used) begin
          state_d = ST_DONE;
        end else if (j_q == two) begin
          state_d = ST_WR_RD;
        end else begin
          state_d = ST_CHK_RD;
        end
      end
      ST_WR_RD: begin
        state_d = ST_WR_EVAL;
      end
      ST_WR_EVAL: begin
        state_d = (j_q == two) ? ST_DONE : ST_WR_RD;
      end
      ST_DONE: begin
        if (done_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and map port controls.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cfg_ready_o = 1'b1;
    ram_re      = 1'b0;
    ram_raddr   = AW'(cur_slot >> BIT_W);
    ram_we      = 1'b0;
    ram_waddr   = rdw_q;
    ram_wdata   = word;
    case (state_q)
      ST_SCAN: begin
        ram_raddr = w_q[AW-1:0];
        ram_re    = (w_q < (AW + 1)'(WORDS));
        if (rvalid_q && kind_q == KIND_ALLOC_FIRST && scan.ff_found) begin
          ram_we    = 1'b1;
          ram_wdata = word | ff_mask;
        end
      end
      ST_CHK_RD, ST_WR_RD: begin
        ram_re = 1'b1;
      end
      ST_WR_EVAL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cur_slot >> BIT_W);
        ram_wdata = val_q ? (word | cur_onehot) : (word & ~cur_onehot);
      end
      default: begin
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    s_d         = s_q;
    j_d         = j_q;
    val_d       = val_q;
    alloc_d     = alloc_q;
    next_d      = next_q;
    w_d         = w_q;
    rdw_d       = ram_raddr;
    rvalid_d    = ram_re && (state_q == ST_SCAN);
    ok_d        = ok_q;
    res_d       = res_q;
    used_d      = used_q;
    hw_d        = hw_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_DISPATCH: begin
        s_d     = idx_q;
        j_d     = 1'b0;
        val_d   = (kind_q == KIND_RESERVE);
        alloc_d = 1'b0;
        next_d  = '0;
        w_d     = '0;
        ok_d    = 1'b0;
        res_d   = '0;
        used_d  = 1'b0;
      end
      ST_SCAN: begin
        if (ram_re) w_d = w_q + (AW + 1)'(1);
        if (rvalid_q) begin
          if (kind_q == KIND_ALLOC_FIRST) begin
            if (scan.ff_found) begin
              ok_d  = 1'b1;
              res_d = ff_slot;
              hw_d  = raise_hw(hw_q, ff_slot + 8'(two));
            end
          end else if (scan.hi_found) begin
            next_d = 9'(eval_base | 10'(scan.hi_bit)) + 9'd1;
          end
        end
      end
      ST_FEND: begin
        s_d     = aligned[7:0];
        j_d     = 1'b0;
        val_d   = 1'b1;
        alloc_d = 1'b1;
      end
      ST_CHK_EVAL: begin
        if (kind_q == KIND_QUERY) begin
          ok_d   = 1'b1;
          used_d = cur_used;
        end else if (!cur_used) begin
          if (j_q == two) begin
            j_d     = 1'b0;
            val_d   = 1'b1;
            alloc_d = 1'b1;
          end else begin
            j_d = 1'b1;
          end
        end
      end
      ST_WR_EVAL: begin
        if (j_q == two) begin
          ok_d = 1'b1;
          if (alloc_q) begin
            res_d = s_q;
            hw_d  = raise_hw(hw_q, s_q + 8'(two));
          end
        end else begin
          j_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (done_load) out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 9'(MAX_SLOTS);
      hw_q        <= -9'sd1;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      rvalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
      rvalid_q    <= rvalid_d;
      if (cfg_valid_i) active_q <= cfg_active_slots_i;
      if (ram_we) vld_q[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      idx_q  <= slot_index_i;
      span_q <= span_slots_i;
    end
    s_q      <= s_d;
    j_q      <= j_d;
    val_q    <= val_d;
    alloc_q  <= alloc_d;
    next_q   <= next_d;
    w_q      <= w_d;
    rdw_q    <= rdw_d;
    rd_vld_q <= vld_q[ram_raddr];
    ok_q     <= ok_d;
    res_q    <= res_d;
    used_q   <= used_d;
    if (done_load) begin
      out_ok_q   <= ok_q;
      out_res_q  <= res_q;
      out_used_q <= used_q;
      out_hw_q   <= hw_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign result_slot_o = out_res_q;
  assign slot_used_o   = out_used_q;
  assign high_water_o  = out_hw_q;

endmodule
